>>> sv/aabb_stc_pkg.sv
// ---------------------------------------------------------------------------
// aabb_stc_pkg: shared types and constants for the AABB slot table
// Command and result codes, field widths, controller/datapath structs.
// ---------------------------------------------------------------------------
package aabb_stc_pkg;

	localparam int SLOTS_DEF      = 64;
	localparam int COORD_BITS_DEF = 24;

	localparam int CMD_W  = 3;
	localparam int IDX_W  = 6;
	localparam int TAG_W  = 9;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 7;

	// tag pattern for "no group"
	localparam logic [TAG_W-1:0] TAG_NONE = 9'h1FF;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE    = 3'd0,
		CMD_QUERY     = 3'd1,
		CMD_ERASE     = 3'd2,
		CMD_ERASE_TAG = 3'd3,
		CMD_SET_TAG   = 3'd4,
		CMD_READ      = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	// how the result beat is built
	typedef enum logic [2:0] {
		RES_ZERO  = 3'd0,
		RES_SLOT  = 3'd1,
		RES_FULL  = 3'd2,
		RES_MISS  = 3'd3,
		RES_COUNT = 3'd4,
		RES_READ  = 3'd5
	} res_kind_t;

	typedef struct packed {
		logic      load;
		logic      rd_en;
		logic      rd_sel_idx;
		logic      create_en;
		logic      sweep_en;
		logic      erase_idx;
		logic      set_tag;
		logic      res_load;
		res_kind_t res_kind;
		logic      out_load;
	} dp_ctrl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             scan_end;
		logic             s1_vld;
		logic             s1_hit;
		logic             s1_free;
	} dp_stat_t;

endpackage

>>> sv/aabb_stc_dp.sv
// ---------------------------------------------------------------------------
// aabb_stc_dp: slot table datapath
// Box and tag memories, flag vectors, scan counter, overlap compare,
// result and output registers.
// ---------------------------------------------------------------------------
module aabb_stc_dp #(
	parameter int SLOTS      = aabb_stc_pkg::SLOTS_DEF,
	parameter int COORD_BITS = aabb_stc_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  aabb_stc_pkg::dp_ctrl_t                 ctl,
	output aabb_stc_pkg::dp_stat_t                 stat,
	input  logic [aabb_stc_pkg::CMD_W-1:0]         command,
	input  logic signed [COORD_BITS-1:0]           centre_x,
	input  logic signed [COORD_BITS-1:0]           centre_y,
	input  logic signed [COORD_BITS-1:0]           centre_z,
	input  logic [COORD_BITS-2:0]                  half_x,
	input  logic [COORD_BITS-2:0]                  half_y,
	input  logic [COORD_BITS-2:0]                  half_z,
	input  logic [aabb_stc_pkg::IDX_W-1:0]         slot_index,
	input  logic signed [aabb_stc_pkg::TAG_W-1:0]  group_tag,
	output logic [aabb_stc_pkg::STAT_W-1:0]        status,
	output logic [aabb_stc_pkg::IDX_W-1:0]         slot_found,
	output logic                                   slot_occupied,
	output logic signed [COORD_BITS-1:0]           read_centre_x,
	output logic signed [COORD_BITS-1:0]           read_centre_y,
	output logic signed [COORD_BITS-1:0]           read_centre_z,
	output logic [COORD_BITS-2:0]                  read_half_x,
	output logic [COORD_BITS-2:0]                  read_half_y,
	output logic [COORD_BITS-2:0]                  read_half_z,
	output logic [aabb_stc_pkg::CNT_W-1:0]         erased_count
);
	import aabb_stc_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = 2 * COORD_BITS - 1;

	// command registers
	logic [CMD_W-1:0]             cmd_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q, cz_q;
	logic [COORD_BITS-2:0]        hx_q, hy_q, hz_q;
	logic [IDX_W-1:0]             idx_q;
	logic [TAG_W-1:0]             tag_q;

	// table state
	logic [EW-1:0]    box_x_mem [SLOTS];
	logic [EW-1:0]    box_y_mem [SLOTS];
	logic [EW-1:0]    box_z_mem [SLOTS];
	logic [TAG_W-1:0] tag_mem   [SLOTS];
	logic [SLOTS-1:0] occ_q;
	logic [SLOTS-1:0] box_ok_q;
	logic [SLOTS-1:0] tag_ok_q;

	logic [CW-1:0]    scan_q;
	logic [CNT_W-1:0] cnt_q;

	// read stage
	logic             s1_vld_s1;
	logic [AW-1:0]    s1_idx_s1;
	logic [EW-1:0]    bx_s1, by_s1, bz_s1;
	logic [TAG_W-1:0] tag_s1;
	logic             occ_s1, box_ok_s1, tag_ok_s1;

	// result and output registers
	logic [STAT_W-1:0]            res_status_q, out_status_q;
	logic [IDX_W-1:0]             res_slot_q, out_slot_q;
	logic                         res_occ_q, out_occ_q;
	logic signed [COORD_BITS-1:0] res_cx_q, res_cy_q, res_cz_q;
	logic signed [COORD_BITS-1:0] out_cx_q, out_cy_q, out_cz_q;
	logic [COORD_BITS-2:0]        res_hx_q, res_hy_q, res_hz_q;
	logic [COORD_BITS-2:0]        out_hx_q, out_hy_q, out_hz_q;
	logic [CNT_W-1:0]             res_cnt_q, out_cnt_q;

	logic [31:0]      idx_w;
	logic [AW-1:0]    idx_addr, scan_addr, rd_addr, tag_wa;
	logic             idx_ok, scan_inc;
	logic             s1_hit, s1_free;
	logic             box_we, sweep_hit, erase_hit, set_hit, tag_we;
	logic [TAG_W-1:0] tag_eff, tag_wd;

	// strict overlap on one axis, one extra bit keeps sums exact
	function automatic logic axis_hit(
		input logic signed [COORD_BITS-1:0] qc,
		input logic [COORD_BITS-2:0]        qh,
		input logic [EW-1:0]                e
	);
		logic signed [COORD_BITS:0] qcs, qhs, scs, shs;
		qcs = {qc[COORD_BITS-1], qc};
		qhs = {2'b00, qh};
		scs = {e[EW-1], e[EW-1:COORD_BITS-1]};
		shs = {2'b00, e[COORD_BITS-2:0]};
		return (qcs + qhs > scs - shs) && (qcs - qhs < scs + shs);
	endfunction

	function automatic logic [IDX_W-1:0] to_slot(input logic [AW-1:0] a);
		logic [31:0] w;
		w = 32'(a);
		return w[IDX_W-1:0];
	endfunction

	assign idx_w     = 32'(idx_q);
	assign idx_addr  = idx_w[AW-1:0];
	assign idx_ok    = (idx_w < 32'(SLOTS));
	assign scan_addr = scan_q[AW-1:0];
	assign rd_addr   = ctl.rd_sel_idx ? idx_addr : scan_addr;
	assign scan_inc  = ctl.rd_en & ~ctl.rd_sel_idx;

	assign tag_eff = tag_ok_s1 ? tag_s1 : '0;
	assign s1_free = s1_vld_s1 & ~occ_s1;
	assign s1_hit  = s1_vld_s1 & occ_s1
		& axis_hit(cy_q, hy_q, by_s1)
		& axis_hit(cx_q, hx_q, bx_s1)
		& axis_hit(cz_q, hz_q, bz_s1);

	assign box_we    = ctl.create_en & s1_free;
	assign sweep_hit = ctl.sweep_en & s1_vld_s1 & (tag_eff == tag_q);
	assign erase_hit = ctl.erase_idx & idx_ok;
	assign set_hit   = ctl.set_tag & idx_ok;
	assign tag_we    = sweep_hit | erase_hit | set_hit;
	assign tag_wa    = sweep_hit ? s1_idx_s1 : idx_addr;
	assign tag_wd    = set_hit ? tag_q : TAG_NONE;

	assign stat.cmd      = cmd_q;
	assign stat.scan_end = (scan_q == CW'(SLOTS));
	assign stat.s1_vld   = s1_vld_s1;
	assign stat.s1_hit   = s1_hit;
	assign stat.s1_free  = s1_free;

	// command capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			cx_q  <= centre_x;
			cy_q  <= centre_y;
			cz_q  <= centre_z;
			hx_q  <= half_x;
			hy_q  <= half_y;
			hz_q  <= half_z;
			idx_q <= slot_index;
			tag_q <= group_tag;
		end
	end

	// memories: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (box_we) begin
			box_x_mem[s1_idx_s1] <= {cx_q, hx_q};
			box_y_mem[s1_idx_s1] <= {cy_q, hy_q};
			box_z_mem[s1_idx_s1] <= {cz_q, hz_q};
		end
		if (tag_we)
			tag_mem[tag_wa] <= tag_wd;
		if (ctl.rd_en) begin
			bx_s1     <= box_x_mem[rd_addr];
			by_s1     <= box_y_mem[rd_addr];
			bz_s1     <= box_z_mem[rd_addr];
			tag_s1    <= tag_mem[rd_addr];
			occ_s1    <= occ_q[rd_addr];
			box_ok_s1 <= box_ok_q[rd_addr];
			tag_ok_s1 <= tag_ok_q[rd_addr];
			s1_idx_s1 <= rd_addr;
		end
	end

	// flags, entry valid bits, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			box_ok_q  <= '0;
			tag_ok_q  <= '0;
			s1_vld_s1 <= 1'b0;
			scan_q    <= '0;
			cnt_q     <= '0;
		end else begin
			s1_vld_s1 <= ctl.rd_en;
			if (ctl.load)
				scan_q <= '0;
			else if (scan_inc)
				scan_q <= scan_q + CW'(1);
			if (ctl.load)
				cnt_q <= '0;
			else if (sweep_hit)
				cnt_q <= cnt_q + CNT_W'(1);
			if (box_we) begin
				occ_q[s1_idx_s1]    <= 1'b1;
				box_ok_q[s1_idx_s1] <= 1'b1;
			end
			if (sweep_hit)
				occ_q[s1_idx_s1] <= 1'b0;
			if (erase_hit)
				occ_q[idx_addr] <= 1'b0;
			if (tag_we)
				tag_ok_q[tag_wa] <= 1'b1;
		end
	end

	// result build
	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			res_status_q <= ST_DONE;
			res_slot_q   <= '0;
			res_occ_q    <= 1'b0;
			res_cx_q     <= '0;
			res_cy_q     <= '0;
			res_cz_q     <= '0;
			res_hx_q     <= '0;
			res_hy_q     <= '0;
			res_hz_q     <= '0;
			res_cnt_q    <= '0;
			case (ctl.res_kind)
				RES_SLOT: begin
					res_slot_q <= to_slot(s1_idx_s1);
				end
				RES_FULL: begin
					res_status_q <= ST_FULL;
				end
				RES_MISS: begin
					res_status_q <= ST_MISS;
				end
				RES_COUNT: begin
					res_cnt_q <= cnt_q;
				end
				RES_READ: begin
					res_slot_q <= idx_q;
					if (idx_ok) begin
						res_occ_q <= occ_s1;
						if (box_ok_s1) begin
							res_cx_q <= bx_s1[EW-1:COORD_BITS-1];
							res_cy_q <= by_s1[EW-1:COORD_BITS-1];
							res_cz_q <= bz_s1[EW-1:COORD_BITS-1];
							res_hx_q <= bx_s1[COORD_BITS-2:0];
							res_hy_q <= by_s1[COORD_BITS-2:0];
							res_hz_q <= bz_s1[COORD_BITS-2:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_occ_q    <= res_occ_q;
			out_cx_q     <= res_cx_q;
			out_cy_q     <= res_cy_q;
			out_cz_q     <= res_cz_q;
			out_hx_q     <= res_hx_q;
			out_hy_q     <= res_hy_q;
			out_hz_q     <= res_hz_q;
			out_cnt_q    <= res_cnt_q;
		end
	end

	assign status        = out_status_q;
	assign slot_found    = out_slot_q;
	assign slot_occupied = out_occ_q;
	assign read_centre_x = out_cx_q;
	assign read_centre_y = out_cy_q;
	assign read_centre_z = out_cz_q;
	assign read_half_x   = out_hx_q;
	assign read_half_y   = out_hy_q;
	assign read_half_z   = out_hz_q;
	assign erased_count  = out_cnt_q;

endmodule

>>> sv/aabb_stc_ctrl.sv
// ---------------------------------------------------------------------------
// aabb_stc_ctrl: slot table controller
// Sequences one command at a time: decode, scan, result, output beat.
// ---------------------------------------------------------------------------
module aabb_stc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  aabb_stc_pkg::dp_stat_t stat,
	output aabb_stc_pkg::dp_ctrl_t ctl
);
	import aabb_stc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EXEC   = 7'b0000010,
		S_CREATE = 7'b0000100,
		S_QUERY  = 7'b0001000,
		S_SWEEP  = 7'b0010000,
		S_READ   = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl     = '0;
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_n  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.cmd)
					CMD_CREATE:    state_n = S_CREATE;
					CMD_QUERY:     state_n = S_QUERY;
					CMD_ERASE_TAG: state_n = S_SWEEP;
					CMD_ERASE: begin
						ctl.erase_idx = 1'b1;
						ctl.res_load  = 1'b1;
						ctl.res_kind  = RES_ZERO;
						state_n       = S_FIN;
					end
					CMD_SET_TAG: begin
						ctl.set_tag  = 1'b1;
						ctl.res_load = 1'b1;
						ctl.res_kind = RES_ZERO;
						state_n      = S_FIN;
					end
					CMD_READ: begin
						ctl.rd_en      = 1'b1;
						ctl.rd_sel_idx = 1'b1;
						state_n        = S_READ;
					end
					default: begin
						ctl.res_load = 1'b1;
						ctl.res_kind = RES_ZERO;
						state_n      = S_FIN;
					end
				endcase
			end
			S_CREATE: begin
				ctl.create_en = 1'b1;
				if (stat.s1_free) begin
					ctl.res_load = 1'b1;
					ctl.res_kind = RES_SLOT;
					state_n      = S_FIN;
				end else if (stat.scan_end) begin
					if (!stat.s1_vld) begin
						ctl.res_load = 1'b1;
						ctl.res_kind = RES_FULL;
						state_n      = S_FIN;
					end
				end else begin
					ctl.rd_en = 1'b1;
				end
			end
			S_QUERY: begin
				if (stat.s1_hit) begin
					ctl.res_load = 1'b1;
					ctl.res_kind = RES_SLOT;
					state_n      = S_FIN;
				end else if (stat.scan_end) begin
					if (!stat.s1_vld) begin
						ctl.res_load = 1'b1;
						ctl.res_kind = RES_MISS;
						state_n      = S_FIN;
					end
				end else begin
					ctl.rd_en = 1'b1;
				end
			end
			S_SWEEP: begin
				ctl.sweep_en = 1'b1;
				if (stat.scan_end) begin
					if (!stat.s1_vld) begin
						ctl.res_load = 1'b1;
						ctl.res_kind = RES_COUNT;
						state_n      = S_FIN;
					end
				end else begin
					ctl.rd_en = 1'b1;
				end
			end
			S_READ: begin
				ctl.res_load = 1'b1;
				ctl.res_kind = RES_READ;
				state_n      = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/aabb_slot_table_collider_unit.sv
// ---------------------------------------------------------------------------
// aabb_slot_table_collider_unit: table of axis-aligned boxes with overlap test
// Create, overlap query, erase, erase by tag, set tag and read slot commands
// over a table of SLOTS boxes; one result beat per command beat.
// ---------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_ready | command, centre_x/y/z, half_x/y/z,
//          |                     | slot_index, group_tag
//  out     | out_valid/out_ready | status, slot_found, slot_occupied,
//          |                     | read_centre_x/y/z, read_half_x/y/z,
//          |                     | erased_count
//
// Scans: create, query and erase by tag walk the box and tag memories
//   through their single read port, one slot per cycle (create stops at
//   the first free slot, query at the first hit); erase, set tag, read
//   slot and unknown commands do not scan.
// Reset: occupied flags and per-slot written bits clear at once, so an
//   unwritten slot reads as zero; there is no clearing pass.
// Stalls: a finished result sits in the output register while the next
//   command beat is taken and worked on; only the final handoff waits on
//   out_ready.
//
module aabb_slot_table_collider_unit #(
	parameter int SLOTS      = aabb_stc_pkg::SLOTS_DEF,
	parameter int COORD_BITS = aabb_stc_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [aabb_stc_pkg::CMD_W-1:0]         command,
	input  logic signed [COORD_BITS-1:0]           centre_x,
	input  logic signed [COORD_BITS-1:0]           centre_y,
	input  logic signed [COORD_BITS-1:0]           centre_z,
	input  logic [COORD_BITS-2:0]                  half_x,
	input  logic [COORD_BITS-2:0]                  half_y,
	input  logic [COORD_BITS-2:0]                  half_z,
	input  logic [aabb_stc_pkg::IDX_W-1:0]         slot_index,
	input  logic signed [aabb_stc_pkg::TAG_W-1:0]  group_tag,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [aabb_stc_pkg::STAT_W-1:0]        status,
	output logic [aabb_stc_pkg::IDX_W-1:0]         slot_found,
	output logic                                   slot_occupied,
	output logic signed [COORD_BITS-1:0]           read_centre_x,
	output logic signed [COORD_BITS-1:0]           read_centre_y,
	output logic signed [COORD_BITS-1:0]           read_centre_z,
	output logic [COORD_BITS-2:0]                  read_half_x,
	output logic [COORD_BITS-2:0]                  read_half_y,
	output logic [COORD_BITS-2:0]                  read_half_z,
	output logic [aabb_stc_pkg::CNT_W-1:0]         erased_count
);
	import aabb_stc_pkg::*;

	// controller drives the datapath through one command struct and sees
	// scan end, read-stage valid, hit and free slot status back
	dp_ctrl_t ctl;
	dp_stat_t stat;

	aabb_stc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// datapath: box/tag memories with registered read, flags, scan counter,
	// three-axis strict overlap compare, result and output registers
	aabb_stc_dp #(
		.SLOTS      (SLOTS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.command       (command),
		.centre_x      (centre_x),
		.centre_y      (centre_y),
		.centre_z      (centre_z),
		.half_x        (half_x),
		.half_y        (half_y),
		.half_z        (half_z),
		.slot_index    (slot_index),
		.group_tag     (group_tag),
		.status        (status),
		.slot_found    (slot_found),
		.slot_occupied (slot_occupied),
		.read_centre_x (read_centre_x),
		.read_centre_y (read_centre_y),
		.read_centre_z (read_centre_z),
		.read_half_x   (read_half_x),
		.read_half_y   (read_half_y),
		.read_half_z   (read_half_z),
		.erased_count  (erased_count)
	);

endmodule
